// File: src/bdlp_pkg.sv
// Shared types and constants for the button debounce and long press unit
`default_nettype none

package bdlp_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int NOW_W = 32;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 8'd1;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG  = 2'd2
	} ev_t;

	typedef struct packed {
		logic             up_level;
		logic             select_level;
		logic [NOW_W-1:0] now_ms;
	} poll_t;

	typedef struct packed {
		logic [1:0] up_event;
		logic [1:0] select_event;
		logic       up_beep;
		logic       select_beep;
	} result_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] long_press_ms;
	} cfg_t;

	// per-button outcome of one poll
	typedef struct packed {
		ev_t  ev;
		logic beep;
	} btn_res_t;

endpackage

`default_nettype wire

// File: src/bdlp_button.sv
// Per-button debounce state and press classification
`default_nettype none

module bdlp_button #(
	parameter int TIME_BITS = bdlp_pkg::TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 level,
	input  wire logic [TIME_BITS-1:0] now,
	input  wire bdlp_pkg::cfg_t       cfg,
	output bdlp_pkg::btn_res_t        res
);

	logic                 last_raw_q;
	logic                 deb_q;
	logic [TIME_BITS-1:0] change_stamp_q;
	logic [TIME_BITS-1:0] press_stamp_q;
	logic                 long_rep_q;

	logic                 raw_chg;
	logic                 settle;
	logic                 deb_n;
	logic [TIME_BITS-1:0] press_n;
	logic                 lr_n;
	logic                 long_hit;
	logic [TIME_BITS-1:0] dt_chg;
	logic [TIME_BITS-1:0] dt_press;

	assign raw_chg = level != last_raw_q;
	assign dt_chg  = now - change_stamp_q;
	assign settle  = !raw_chg && (level != deb_q) && (dt_chg >= TIME_BITS'(cfg.debounce_ms));

	always_comb begin
		deb_n   = deb_q;
		press_n = press_stamp_q;
		lr_n    = long_rep_q;
		if (settle) begin
			deb_n   = level;
			press_n = level ? '0 : now;
			lr_n    = 1'b0;
		end
	end

	// a zero stamp marks no press running
	assign dt_press = now - press_n;
	assign long_hit = !raw_chg && !deb_n && !lr_n && (press_n != '0) &&
		(dt_press >= TIME_BITS'(cfg.long_press_ms));

	always_comb begin
		res.beep = settle && !level;
		res.ev   = bdlp_pkg::EV_NONE;
		if (long_hit) begin
			res.ev = bdlp_pkg::EV_LONG;
		end else if (settle && level && !long_rep_q) begin
			res.ev = bdlp_pkg::EV_SHORT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q     <= 1'b1;
			deb_q          <= 1'b1;
			change_stamp_q <= '0;
			press_stamp_q  <= '0;
			long_rep_q     <= 1'b0;
		end else if (en) begin
			if (raw_chg) begin
				last_raw_q     <= level;
				change_stamp_q <= now;
			end else begin
				deb_q         <= deb_n;
				press_stamp_q <= press_n;
				long_rep_q    <= lr_n | long_hit;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/button_debounce_long_press_unit.sv
// Top level: poll register, two button slices, result register, config registers
//
//  channel  signals                           word
//  in       in_valid / in_ready / in_data     poll_t: two raw levels, ms timestamp
//  out      out_valid / out_ready / out_data  result_t: events and beeps per button
//  cfg      cfg_valid / cfg_ready             cfg_index, cfg_data (low 16 bits kept)
//
// One poll per cycle unless the result stalls; the result is registered.
// The input register feeds the button slices, whose state and the result
// register load together on the same edge, so back-to-back polls see fresh state.
// A stalled result holds the input register; in_ready drops only when both are full.
// Reset restores released levels, zero stamps and the default times.
`default_nettype none

module button_debounce_long_press_unit #(
	parameter int TIME_BITS = bdlp_pkg::TIME_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire bdlp_pkg::poll_t                   in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output bdlp_pkg::result_t                      out_data,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [bdlp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bdlp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	bdlp_pkg::cfg_t     cfg_q;
	bdlp_pkg::poll_t    poll_s1;
	logic               valid_s1;
	bdlp_pkg::result_t  out_q;
	logic               out_valid_q;
	logic               adv;
	logic               fire;
	logic [TIME_BITS-1:0] now_t;
	bdlp_pkg::btn_res_t up_res;
	bdlp_pkg::btn_res_t sel_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= bdlp_pkg::DEBOUNCE_RST;
			cfg_q.long_press_ms <= bdlp_pkg::LONG_PRESS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				bdlp_pkg::REG_DEBOUNCE:   cfg_q.debounce_ms   <= cfg_data[bdlp_pkg::CFG_W-1:0];
				bdlp_pkg::REG_LONG_PRESS: cfg_q.long_press_ms <= cfg_data[bdlp_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv      = !out_valid_q || out_ready;
	assign fire     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			poll_s1 <= in_data;
		end
	end

	assign now_t = TIME_BITS'(poll_s1.now_ms);

	bdlp_button #(.TIME_BITS(TIME_BITS)) u_up (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire),
		.level  (poll_s1.up_level),
		.now    (now_t),
		.cfg    (cfg_q),
		.res    (up_res)
	);

	bdlp_button #(.TIME_BITS(TIME_BITS)) u_sel (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire),
		.level  (poll_s1.select_level),
		.now    (now_t),
		.cfg    (cfg_q),
		.res    (sel_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.up_event     <= up_res.ev;
			out_q.select_event <= sel_res.ev;
			out_q.up_beep      <= up_res.beep;
			out_q.select_beep  <= sel_res.beep;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_no_bad_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.up_event != 2'd3) && (out_data.select_event != 2'd3))
		else $error("event code out of range");

	a_beep_not_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.up_beep |-> out_data.up_event != bdlp_pkg::EV_SHORT)
		else $error("beep together with short event");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a full pipe");

	a_result_from_poll: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1))
		else $error("result without a poll");
`endif

endmodule

`default_nettype wire

// File: bench/button_debounce_long_press_unit_tb.sv
// Self-checking testbench for the two-button debounce and long press unit
module button_debounce_long_press_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_PHASES  = 6;
	localparam int PHASE_POLLS    = 200;
	localparam int NOW_W          = bdlp_pkg::NOW_W;
	localparam int CFG_W          = bdlp_pkg::CFG_W;
	localparam int CFG_IDX_W      = bdlp_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W     = bdlp_pkg::CFG_DATA_W;

	logic                  clk;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	bdlp_pkg::poll_t       in_data    = '0;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	bdlp_pkg::result_t     out_data;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	button_debounce_long_press_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state, index 0 = up, 1 = select
	logic [CFG_W-1:0] debounce_set;
	logic [CFG_W-1:0] long_set;
	logic             raw_seen [2];
	logic             stable_lvl [2];
	logic [NOW_W-1:0] change_t [2];
	logic [NOW_W-1:0] press_t [2];
	logic             long_done [2];

	bdlp_pkg::result_t pending_results [$];
	bdlp_pkg::result_t want;
	int      mismatches  = 0;
	int      idle_cycles = 0;
	int      ready_hold  = 0;
	bit      no_gaps     = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	task automatic step_button(input int b, input logic lvl, input logic [NOW_W-1:0] now,
			output bdlp_pkg::ev_t ev, output logic beep);
		logic [NOW_W-1:0] held;
		ev   = bdlp_pkg::EV_NONE;
		beep = 1'b0;
		if (lvl != raw_seen[b]) begin
			// raw edge only restarts the settle timer
			raw_seen[b] = lvl;
			change_t[b] = now;
		end else begin
			held = now - change_t[b];
			if (lvl != stable_lvl[b] && held >= NOW_W'(debounce_set)) begin
				stable_lvl[b] = lvl;
				if (!lvl) begin
					press_t[b]   = now;
					long_done[b] = 1'b0;
					beep         = 1'b1;
				end else begin
					if (!long_done[b])
						ev = bdlp_pkg::EV_SHORT;
					press_t[b]   = '0;
					long_done[b] = 1'b0;
				end
			end
			// a press stamped at zero counts as no press running
			held = now - press_t[b];
			if (!stable_lvl[b] && !long_done[b] && press_t[b] != '0 &&
					held >= NOW_W'(long_set)) begin
				long_done[b] = 1'b1;
				ev           = bdlp_pkg::EV_LONG;
			end
		end
	endtask

	task automatic predict_poll(input bdlp_pkg::poll_t p, output bdlp_pkg::result_t r);
		bdlp_pkg::ev_t ev_up, ev_sel;
		logic          bp_up, bp_sel;
		step_button(0, p.up_level, p.now_ms, ev_up, bp_up);
		step_button(1, p.select_level, p.now_ms, ev_sel, bp_sel);
		r.up_event     = ev_up;
		r.select_event = ev_sel;
		r.up_beep      = bp_up;
		r.select_beep  = bp_sel;
	endtask

	task automatic send_poll(input logic up, input logic sel, input logic [NOW_W-1:0] now);
		bdlp_pkg::poll_t   p;
		bdlp_pkg::result_t r;
		int                gap;
		p.up_level     = up;
		p.select_level = sel;
		p.now_ms       = now;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_poll(p, r);
		pending_results.push_back(r);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == bdlp_pkg::REG_DEBOUNCE)
			debounce_set = data[CFG_W-1:0];
		else if (idx == bdlp_pkg::REG_LONG_PRESS)
			long_set = data[CFG_W-1:0];
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// block is idle once every expected word is back and the pipe has emptied
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_default_timing();
		no_gaps = 1'b0;
		send_poll(1'b1, 1'b1, 32'd0);
		send_poll(1'b0, 1'b1, 32'd100);
		send_poll(1'b0, 1'b1, 32'd149);
		send_poll(1'b0, 1'b1, 32'd150);
		send_poll(1'b0, 1'b0, 32'd1149);
		send_poll(1'b0, 1'b0, 32'd1150);
		send_poll(1'b1, 1'b0, 32'd1300);
		send_poll(1'b1, 1'b1, 32'd1400);
		send_poll(1'b1, 1'b1, 32'd1500);
		drain_results();
	endtask

	task automatic test_time_wrap_and_zero();
		write_reg(bdlp_pkg::REG_DEBOUNCE, 32'd10);
		write_reg(bdlp_pkg::REG_LONG_PRESS, 32'd20);
		// select settles exactly at time zero, so no long event may follow
		send_poll(1'b1, 1'b0, 32'hFFFF_FFF6);
		send_poll(1'b1, 1'b0, 32'h0000_0000);
		send_poll(1'b1, 1'b0, 32'd5000);
		send_poll(1'b0, 1'b1, 32'hFFFF_FFFF);
		send_poll(1'b0, 1'b1, 32'd9);
		send_poll(1'b0, 1'b1, 32'd29);
		drain_results();
		// zero long time: beep and long event on the same poll
		write_reg(bdlp_pkg::REG_LONG_PRESS, 32'd0);
		send_poll(1'b1, 1'b1, 32'd100);
		send_poll(1'b1, 1'b1, 32'd110);
		send_poll(1'b0, 1'b1, 32'd200);
		send_poll(1'b0, 1'b1, 32'd210);
		drain_results();
		write_reg(bdlp_pkg::REG_DEBOUNCE, 32'd0);
		send_poll(1'b1, 1'b1, 32'd210);
		send_poll(1'b1, 1'b1, 32'd210);
		drain_results();
	endtask

	task automatic test_register_writes();
		logic [NOW_W-1:0] t0;
		write_reg(8'd2, $urandom());
		write_reg(8'hFF, $urandom());
		write_reg(bdlp_pkg::REG_DEBOUNCE, 32'hABCD_0003);
		write_reg(bdlp_pkg::REG_LONG_PRESS, 32'hFFFF_0007);
		send_poll(1'b0, 1'b0, 32'd1000);
		send_poll(1'b0, 1'b0, 32'd1003);
		send_poll(1'b0, 1'b0, 32'd1010);
		drain_results();
		write_reg(bdlp_pkg::REG_DEBOUNCE, 32'h0000_FFFF);
		write_reg(bdlp_pkg::REG_LONG_PRESS, 32'h0000_FFFF);
		t0 = 32'hFFFE_0000;
		send_poll(1'b1, 1'b1, t0);
		send_poll(1'b1, 1'b1, t0 + 32'd65535);
		send_poll(1'b0, 1'b0, t0 + 32'd65536);
		send_poll(1'b0, 1'b0, t0 + 32'd131070);
		send_poll(1'b0, 1'b0, t0 + 32'd131071);
		send_poll(1'b0, 1'b0, t0 + 32'd196606);
		drain_results();
	endtask

	task automatic test_random_polls();
		logic [NOW_W-1:0] t;
		logic             aim_up, aim_sel, up, sel;
		int               scale, r;
		aim_up  = 1'b1;
		aim_sel = 1'b1;
		t = $urandom();
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					write_reg(bdlp_pkg::REG_DEBOUNCE, 32'd0);
					write_reg(bdlp_pkg::REG_LONG_PRESS, 32'd0);
				end
				1: begin
					write_reg(bdlp_pkg::REG_DEBOUNCE, 32'd65535);
					write_reg(bdlp_pkg::REG_LONG_PRESS, 32'd65535);
				end
				default: begin
					r = $urandom_range(0, 3);
					write_reg(bdlp_pkg::REG_DEBOUNCE, (r == 0) ? $urandom() :
						(r == 1) ? $urandom_range(0, 200) : $urandom_range(0, 20));
					r = $urandom_range(0, 3);
					write_reg(bdlp_pkg::REG_LONG_PRESS, (r == 0) ? $urandom() :
						(r == 1) ? $urandom_range(0, 2000) : $urandom_range(0, 100));
					if ($urandom_range(0, 1))
						write_reg(CFG_IDX_W'($urandom_range(2, 255)), $urandom());
				end
			endcase
			no_gaps = ($urandom_range(0, 2) == 0);
			scale = ((debounce_set > long_set) ? debounce_set : long_set) / 3 + 3;
			for (int n = 0; n < PHASE_POLLS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 5)
					t = $urandom();
				else if (r < 7)
					t = 32'hFFFF_FFFF - NOW_W'($urandom_range(0, 2 * scale));
				else
					t = t + NOW_W'($urandom_range(0, scale));
				if ($urandom_range(0, 7) == 0)
					aim_up = ~aim_up;
				if ($urandom_range(0, 7) == 0)
					aim_sel = ~aim_sel;
				// mostly held levels with the odd bounce, a little pure noise
				up  = ($urandom_range(0, 9) == 0) ? ~aim_up : aim_up;
				sel = ($urandom_range(0, 9) == 0) ? ~aim_sel : aim_sel;
				if ($urandom_range(0, 19) == 0) begin
					up  = 1'($urandom_range(0, 1));
					sel = 1'($urandom_range(0, 1));
				end
				send_poll(up, sel, t);
			end
			drain_results();
		end
	endtask

	// result side: random back-pressure
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			out_ready  <= 1'b0;
		end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
			ready_hold <= pick_gap();
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result word with none expected: %p", $realtime, out_data);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.up_event !== want.up_event ||
						out_data.select_event !== want.select_event ||
						out_data.up_beep !== want.up_beep ||
						out_data.select_beep !== want.select_beep) begin
					if (mismatches < 10)
						$display({"%0t: mismatch up_ev exp %0d act %0d, ",
							"sel_ev exp %0d act %0d, up_beep exp %0b act %0b, ",
							"sel_beep exp %0b act %0b"},
							$realtime, want.up_event, out_data.up_event,
							want.select_event, out_data.select_event,
							want.up_beep, out_data.up_beep,
							want.select_beep, out_data.select_beep);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		debounce_set = bdlp_pkg::DEBOUNCE_RST;
		long_set     = bdlp_pkg::LONG_PRESS_RST;
		for (int b = 0; b < 2; b++) begin
			raw_seen[b]   = 1'b1;
			stable_lvl[b] = 1'b1;
			change_t[b]   = '0;
			press_t[b]    = '0;
			long_done[b]  = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_timing();
		test_time_wrap_and_zero();
		test_register_writes();
		test_random_polls();

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
